// ===== rtl/core/ps2kbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Shared types, constants and translation tables of the set-1 keyboard decoder.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

  // character store
  localparam int unsigned FifoDepth = 64;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  // queue between decoder and character store
  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // scan codes
  localparam logic [7:0] ScLShift = 8'h2A;
  localparam logic [7:0] ScRShift = 8'h36;
  localparam logic [7:0] ScCaps   = 8'h3A;
  localparam logic [7:0] ScCtrl   = 8'h1D;
  localparam logic [7:0] ScAlt    = 8'h38;
  localparam logic [7:0] ScPrefix = 8'hE0;
  localparam logic [7:0] ScExtDel = 8'h53;
  localparam logic [7:0] TableLen = 8'h3B;

  localparam logic [6:0] ChNone      = 7'h00;
  localparam logic [6:0] ChBackspace = 7'h08;
  localparam logic [6:0] ChCaseBit   = 7'h20;

  typedef struct packed {
    logic       command;
    logic [7:0] scan_code;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       key_pending;
    logic       dropped;
  } out_item_t;

  // decoded operation passed to the back end
  typedef struct packed {
    logic       is_read;
    logic [6:0] ch;
  } kbd_op_t;

  // tables padded to 64 entries, codes from 0x3b upwards never index them
  localparam logic [6:0] PlainMap [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [6:0] UpperMap [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ps2kbd_front.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_front
// Takes requests, tracks shift, caps-lock and prefix flags, and turns each
// request into a read or a character operation.
// ----------------------------------------------------------------------------
module ps2kbd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2kbd_pkg::in_item_t  in_data_i,
  output logic                  op_valid_o,
  input  logic                  op_ready_i,
  output ps2kbd_pkg::kbd_op_t   op_o
);
  import ps2kbd_pkg::*;

  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic       prefix_q, prefix_d;
  logic [7:0] sc;
  logic [6:0] mk;
  logic [6:0] lut;
  logic [6:0] ch;
  logic       accept;

  assign sc     = in_data_i.scan_code;
  assign mk     = sc[6:0];
  assign accept = in_valid_i && op_ready_i;

  assign lut = shift_q ? UpperMap[sc[5:0]] : PlainMap[sc[5:0]];

  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    ch       = ChNone;
    if (!in_data_i.command) begin
      priority if (sc == ScPrefix) begin
        prefix_d = 1'b1;
      end else if (sc[7]) begin
        // release code
        if (!prefix_q && (mk == ScLShift[6:0] || mk == ScRShift[6:0])) begin
          shift_d = 1'b0;
        end
        prefix_d = 1'b0;
      end else if (prefix_q) begin
        prefix_d = 1'b0;
        ch       = (sc == ScExtDel) ? ChBackspace : ChNone;
      end else if (sc == ScLShift || sc == ScRShift) begin
        shift_d = 1'b1;
      end else if (sc == ScCaps) begin
        caps_d = !caps_q;
      end else if (sc == ScCtrl || sc == ScAlt || sc >= TableLen) begin
        ch = ChNone;
      end else begin
        ch = lut;
        if (caps_q && ((lut >= 7'h61 && lut <= 7'h7A) ||
                       (lut >= 7'h41 && lut <= 7'h5A))) begin
          ch = lut ^ ChCaseBit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (accept) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

  assign in_ready_o    = op_ready_i;
  assign op_valid_o    = in_valid_i;
  assign op_o.is_read  = in_data_i.command;
  assign op_o.ch       = ch;

endmodule

// ===== rtl/core/ps2kbd_queue.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_queue
// Short operation queue between the decoder and the character store.
// ----------------------------------------------------------------------------
module ps2kbd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  ps2kbd_pkg::kbd_op_t  push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output ps2kbd_pkg::kbd_op_t  pop_data_o
);
  import ps2kbd_pkg::*;

  kbd_op_t          slot_q [QDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QIdxW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QIdxW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ps2kbd_back.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_back
// Character ring store with push, pop and drop-on-full, plus the output
// register that presents one result per operation.
// ----------------------------------------------------------------------------
module ps2kbd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_valid_i,
  output logic                   op_ready_o,
  input  ps2kbd_pkg::kbd_op_t    op_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ps2kbd_pkg::out_item_t  out_data_o
);
  import ps2kbd_pkg::*;

  logic [6:0]      mem_q [FifoDepth];
  logic [6:0]      rdata_q;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0] wp_nx;
  logic            out_valid_q;
  logic [6:0]      char_q;
  logic            sel_mem_q;
  logic            pending_q, pending_d;
  logic            dropped_q, dropped_d;
  logic            issue, empty, full;
  logic            do_pop, do_push;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign issue      = op_valid_i && op_ready_o;

  assign empty = (wp_q == rp_q);
  assign wp_nx = ptr_next(wp_q);
  assign full  = (wp_nx == rp_q);

  always_comb begin
    do_pop    = 1'b0;
    do_push   = 1'b0;
    dropped_d = 1'b0;
    wp_d      = wp_q;
    rp_d      = rp_q;
    if (op_i.is_read) begin
      if (!empty) begin
        do_pop = 1'b1;
        rp_d   = ptr_next(rp_q);
      end
    end else if (op_i.ch != ChNone) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        do_push = 1'b1;
        wp_d    = wp_nx;
      end
    end
    pending_d = (wp_d != rp_d);
  end

  always_ff @(posedge clk_i) begin
    if (issue && do_push) begin
      mem_q[wp_q] <= op_i.ch;
    end
  end

  // read data holds while the output is stalled
  always_ff @(posedge clk_i) begin
    if (issue && do_pop) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      char_q    <= op_i.is_read ? ChNone : op_i.ch;
      sel_mem_q <= do_pop;
      pending_q <= pending_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (op_ready_o) begin
        out_valid_q <= op_valid_i;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.char_out    = sel_mem_q ? rdata_q : char_q;
  assign out_data_o.key_pending = pending_q;
  assign out_data_o.dropped     = dropped_q;

endmodule

// ===== rtl/core/ps2_set1_scancode_to_ascii_fifo.sv =====
// ----------------------------------------------------------------------------
// ps2_set1_scancode_to_ascii_fifo
// Set-1 scan code decoder with a character FIFO and read-key requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i): each request is a
// received scan code byte (command 0) or a read of one key (command 1).
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// per request, in order: the produced or popped character (0 if none), the
// pending flag and the dropped flag.
// The request is held in the decoder-side queue once accepted; the store
// update, the registered store read and the output register then all land
// on the same edge, when the back end issues the request.
// Throughput is one request per cycle while the receiver takes results;
// each request does either one push or one pop on the character store.
// The store keeps up to 63 characters; a character produced while it is full
// is still reported but flagged as dropped.
// Reset clears the shift, caps-lock and prefix flags and empties the store;
// no clearing pass, requests are taken from the first cycle after reset.
// If the receiver stalls, the output register holds its result, the 2-entry
// queue fills, and in_ready_o then drops until results are taken.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_to_ascii_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ps2kbd_pkg::in_item_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ps2kbd_pkg::out_item_t  out_data_o
);
  import ps2kbd_pkg::*;

  logic    fr_valid, fr_ready;
  kbd_op_t fr_op;
  logic    bk_valid, bk_ready;
  kbd_op_t bk_op;

  ps2kbd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (fr_valid),
    .op_ready_i (fr_ready),
    .op_o       (fr_op)
  );

  ps2kbd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_op)
  );

  ps2kbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_ready_o  (bk_ready),
    .op_i        (bk_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives scan code and read-key requests into the set-1 keyboard decoder and
// checks every result against a cycle-free model of the decoder and its FIFO.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2kbd_pkg::*;

  localparam logic       CmdScan    = 1'b0;
  localparam logic       CmdRead    = 1'b1;
  localparam logic [7:0] BreakMask  = 8'h80;
  localparam logic [7:0] LastKey    = 8'h39;  // space bar, last mapped make code
  localparam int         RandomReqs = 500;
  localparam int         CycleLimit = 400000;

  localparam logic [6:0] KeyPlain [59] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] KeyShifted [59] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00
  };

  typedef struct {
    in_item_t    req;
    int unsigned gap;
    bit          drain;
  } key_req_t;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  key_req_t   typing_q[$];
  out_item_t  expected_out_q[$];
  logic [6:0] typed_chars_q[$];

  logic shift_pressed = 1'b0;
  logic caps_active   = 1'b0;
  logic ext_pending   = 1'b0;

  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  int          req_total    = 0;
  bit          gap_calm     = 1'b0;
  bit          drain_next   = 1'b0;
  int unsigned gap_left     = 0;
  bit          gap_armed    = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned calm_left    = 0;

  ps2_set1_scancode_to_ascii_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [6:0] decode_scan(input logic [7:0] sc);
    logic [6:0] ch;
    ch = ChNone;
    if (sc == ScPrefix) begin
      ext_pending = 1'b1;
    end else if ((sc & BreakMask) != 0) begin
      // an extended shift release is a fake shift and leaves the flag alone
      if (!ext_pending && (sc[6:0] == ScLShift[6:0] || sc[6:0] == ScRShift[6:0])) begin
        shift_pressed = 1'b0;
      end
      ext_pending = 1'b0;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      if (sc == ScExtDel) begin
        ch = ChBackspace;
      end
    end else if (sc == ScLShift || sc == ScRShift) begin
      shift_pressed = 1'b1;
    end else if (sc == ScCaps) begin
      caps_active = ~caps_active;
    end else if (sc != ScCtrl && sc != ScAlt && sc < TableLen) begin
      ch = shift_pressed ? KeyShifted[sc] : KeyPlain[sc];
      if (caps_active && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))) begin
        ch = ch ^ ChCaseBit;
      end
    end
    return ch;
  endfunction

  function automatic out_item_t kbd_predict(input in_item_t req);
    out_item_t res;
    res = '0;
    if (req.command == CmdRead) begin
      if (typed_chars_q.size() != 0) begin
        res.char_out = typed_chars_q.pop_front();
      end
    end else begin
      res.char_out = decode_scan(req.scan_code);
      if (res.char_out != ChNone) begin
        // one slot stays free so the pointers can tell full from empty
        if (typed_chars_q.size() >= FifoDepth - 1) begin
          res.dropped = 1'b1;
        end else begin
          typed_chars_q.push_back(res.char_out);
        end
      end
    end
    res.key_pending = (typed_chars_q.size() != 0);
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    key_req_t head;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (in_valid) begin
        expected_out_q.push_back(kbd_predict(in_data));
      end
      if (typing_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_armed) begin
          gap_left  = typing_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (typing_q[0].drain && expected_out_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          head      = typing_q.pop_front();
          in_valid  <= 1'b1;
          in_data   <= head.req;
          gap_armed = 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t exp_item;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_out_q.size() == 0) begin
          $error("unexpected result: char_out %0h key_pending %0b dropped %0b",
                 out_data_o.char_out, out_data_o.key_pending, out_data_o.dropped);
          mismatch_cnt++;
        end else begin
          exp_item = expected_out_q.pop_front();
          if (out_data_o.char_out !== exp_item.char_out) begin
            $error("char_out: expected %0h, got %0h", exp_item.char_out, out_data_o.char_out);
            mismatch_cnt++;
          end
          if (out_data_o.key_pending !== exp_item.key_pending) begin
            $error("key_pending: expected %0b, got %0b",
                   exp_item.key_pending, out_data_o.key_pending);
            mismatch_cnt++;
          end
          if (out_data_o.dropped !== exp_item.dropped) begin
            $error("dropped: expected %0b, got %0b", exp_item.dropped, out_data_o.dropped);
            mismatch_cnt++;
          end
        end
        if (calm_left != 0) begin
          calm_left--;
          stall_left = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          calm_left  = $urandom_range(10, 40);
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 9);
        end
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_req(input logic cmd, input logic [7:0] sc);
    key_req_t k;
    k.req.command   = cmd;
    k.req.scan_code = sc;
    k.gap           = gap_calm ? 0 : $urandom_range(0, 9);
    k.drain         = drain_next;
    drain_next      = 1'b0;
    typing_q.push_back(k);
    req_total++;
  endtask

  function automatic logic [7:0] pick_key_code();
    logic [7:0] sc;
    do begin
      sc = 8'($urandom_range(1, LastKey));
    end while (sc == ScCtrl || sc == ScAlt || sc == ScLShift || sc == ScRShift);
    return sc;
  endfunction

  // one keystroke as a keyboard would send it, now and then a broken one
  task automatic add_keystroke();
    logic [7:0] sc;
    logic [7:0] sh;
    sc = pick_key_code();
    sh = $urandom_range(0, 1) ? ScLShift : ScRShift;
    case ($urandom_range(0, 9))
      0, 1: begin
        add_req(CmdScan, sh);
        add_req(CmdScan, sc);
        add_req(CmdScan, sc | BreakMask);
        add_req(CmdScan, sh | BreakMask);
      end
      2: begin
        add_req(CmdScan, ScCaps);
        add_req(CmdScan, ScCaps | BreakMask);
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          sc = ScExtDel;
        end
        add_req(CmdScan, ScPrefix);
        add_req(CmdScan, sc);
        add_req(CmdScan, ScPrefix);
        add_req(CmdScan, sc | BreakMask);
      end
      4: begin
        add_req(CmdScan, ScPrefix);
        add_req(CmdScan, 8'($urandom));
      end
      default: begin
        add_req(CmdScan, sc);
        add_req(CmdScan, sc | BreakMask);
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      add_req(CmdRead, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int kind;
    int len;
    // directed part: modifiers, extended codes, unmapped codes, empty reads
    add_req(CmdRead, 8'hFF);
    add_req(CmdScan, 8'h00);
    add_req(CmdScan, 8'h02);
    add_req(CmdScan, 8'h10);
    add_req(CmdScan, 8'h39);
    add_req(CmdScan, ScLShift);
    add_req(CmdScan, 8'h02);
    add_req(CmdScan, ScPrefix);
    add_req(CmdScan, ScLShift | BreakMask);
    add_req(CmdScan, 8'h1E);
    add_req(CmdScan, ScLShift | BreakMask);
    add_req(CmdScan, ScCaps);
    add_req(CmdScan, 8'h10);
    add_req(CmdScan, ScRShift);
    add_req(CmdScan, 8'h10);
    add_req(CmdScan, ScRShift | BreakMask);
    add_req(CmdScan, ScCaps);
    add_req(CmdScan, ScPrefix);
    add_req(CmdScan, ScExtDel);
    add_req(CmdScan, ScPrefix);
    add_req(CmdScan, 8'h48);
    add_req(CmdScan, ScCtrl);
    add_req(CmdScan, ScAlt);
    add_req(CmdScan, TableLen);
    add_req(CmdScan, 8'h7F);
    add_req(CmdScan, 8'hFF);
    repeat (4) add_req(CmdRead, 8'h00);

    // random part, the first phase waits for the pipeline to drain
    drain_next = 1'b1;
    while (req_total < RandomReqs) begin
      kind     = $urandom_range(0, 5);
      len      = $urandom_range(5, 40);
      gap_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        drain_next = 1'b1;
      end
      case (kind)
        0, 1: repeat (len) add_keystroke();
        2: repeat ($urandom_range(10, 80)) add_req(CmdScan, pick_key_code());
        3: repeat ($urandom_range(5, 70)) add_req(CmdRead, 8'($urandom));
        4: repeat (len) add_req(1'($urandom), 8'($urandom));
        default: begin
          repeat (len) begin
            if ($urandom_range(0, 1)) begin
              add_req(CmdRead, 8'($urandom));
            end else begin
              add_keystroke();
            end
          end
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (typing_q.size() != 0 || in_valid || expected_out_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== ps2_set1_scancode_to_ascii_fifo.f =====
rtl/core/ps2kbd_pkg.sv
rtl/core/ps2kbd_front.sv
rtl/core/ps2kbd_queue.sv
rtl/core/ps2kbd_back.sv
rtl/core/ps2_set1_scancode_to_ascii_fifo.sv
sim/testbench.sv
